/* design/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

/* design/tqe_pkg.sv */
//------------------------------------------------------------------------------
// tqe_pkg
// Shared types and codes of the timer queue engine.
//------------------------------------------------------------------------------
package tqe_pkg;
   typedef enum logic [1:0] {
      REQ_ARM = 2'd0, REQ_CANCEL = 2'd1, REQ_TICK = 2'd2, REQ_SET = 2'd3
   } req_type_type;
   localparam logic [2:0] EV_ARMED   = 3'd0;
   localparam logic [2:0] EV_CANCEL  = 3'd1;
   localparam logic [2:0] EV_EXPIRED = 3'd2;
   localparam logic [2:0] EV_TICK    = 3'd3;
   localparam logic [2:0] EV_SET     = 3'd4;
   localparam logic [19:0] INC_RESET = 20'd100;
   localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  tmr;
      logic        cb;
      logic        wa;
      logic        last;
   } ev_type;
endpackage

/* design/timer_queue_engine.sv */
//------------------------------------------------------------------------------
// timer_queue_engine
// Timer table with 64-bit system time; ticks expire due timers in order.
//------------------------------------------------------------------------------
// channel  dir  protocol  payload
// req      in   stream    tdata, tuser = req_type
// rsp      out  stream    tdata, tlast
// csr      in   apb       time_increment at 0x0
// Arm, cancel and set time register their response directly from idle, then hand it off.
// A tick scans one slot per cycle through the shared compare unit,
// rescans after each expiry, and ends with one final scan that finds none due.
// A waiting result holds the next expiry; the scan runs meanwhile.
// Reset is synchronous; tables need none, valid marks are cleared at once.
module timer_queue_engine #(
   parameter int TIMER_SLOTS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,    // req_type
   input  logic [135:0] req_tdata,    // timer_id, due_time, period, has_callback
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata,    // event_kind, event_timer, callback_due,
                                      // prior_pending, active_count, now_time
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   `include "assert_macros.svh"
   localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CW = $clog2(TIMER_SLOTS + 1);

   typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_SCANRD, ST_FIRE, ST_OUT} state_type;

   state_type state_ff;
   logic [19:0] inc_ff;
   logic [63:0] now_ff;
   logic [63:0] due_mem [TIMER_SLOTS];
   logic [62:0] per_mem [TIMER_SLOTS];
   logic [31:0] ord_mem [TIMER_SLOTS];
   logic [TIMER_SLOTS-1:0] pend_ff, perd_ff, cbm_ff, done_ff;
   logic [31:0] seq_ff;
   logic [CW-1:0] cnt_ff;
   logic [IW-1:0] idx_ff, best_ff;
   logic        best_ok_ff;
   logic [63:0] best_due_ff;
   logic [31:0] best_ord_ff;
   logic [63:0] rd_due_ff;
   logic [31:0] rd_ord_ff;
   logic [62:0] rd_per_ff;
   logic        rd_ok_ff;
   logic [IW-1:0] rd_idx_ff;
   logic        scan_end_ff;
   tqe_pkg::ev_type ev_ff;
   logic        ovalid_ff;

   logic [4:0]  in_id;
   logic [63:0] in_due;
   logic [62:0] in_per;
   logic        in_cb, in_ok;
   logic [IW-1:0] in_idx;
   assign in_id  = req_tdata[4:0];
   assign in_due = req_tdata[68:5];
   assign in_per = req_tdata[131:69];
   assign in_cb  = req_tdata[132];
   assign in_ok  = 32'(in_id) < TIMER_SLOTS;
   assign in_idx = IW'(in_id);

   logic is_due, better;
   tqe_cmp u_cmp (
      .cand_due(rd_due_ff), .cand_ord(rd_ord_ff),
      .best_due(best_due_ff), .best_ord(best_ord_ff), .best_ok(best_ok_ff),
      .now(now_ff), .is_due(is_due), .better(better));

   assign req_tready = (state_ff == ST_IDLE) && !ovalid_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = ev_ff.last;
   assign rsp_tdata  = {now_ff, 6'(cnt_ff), ev_ff.wa, ev_ff.cb, ev_ff.tmr, ev_ff.kind};
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? {12'd0, inc_ff} : 32'd0;

   logic csr_wr;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr == 2'd0);

   always_ff @(posedge clock) begin
      rd_due_ff <= due_mem[idx_ff];
      rd_ord_ff <= ord_mem[idx_ff];
      rd_per_ff <= per_mem[best_ff];
      if (reset) begin
         state_ff <= ST_IDLE;
         inc_ff <= tqe_pkg::INC_RESET;
         now_ff <= '0;
         pend_ff <= '0; perd_ff <= '0; cbm_ff <= '0; done_ff <= '0;
         seq_ff <= '0; cnt_ff <= '0; ovalid_ff <= 1'b0;
         idx_ff <= '0; best_ff <= '0; best_ok_ff <= 1'b0;
         rd_ok_ff <= 1'b0; rd_idx_ff <= '0; scan_end_ff <= 1'b0;
         ev_ff <= '0; best_due_ff <= '0; best_ord_ff <= '0;
      end else begin
         if (csr_wr) inc_ff <= csr_pwdata[19:0];
         if (rsp_tvalid && rsp_tready) ovalid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  case (req_tuser)
                     tqe_pkg::REQ_ARM: begin
                        ev_ff <= '{kind: tqe_pkg::EV_ARMED, tmr: in_id, cb: 1'b0,
                                   wa: 1'b0, last: 1'b1};
                        if (in_ok) begin
                           due_mem[in_idx] <= in_due[63] ? now_ff - in_due : in_due;
                           per_mem[in_idx] <= in_per;
                           ord_mem[in_idx] <= seq_ff;
                           seq_ff <= seq_ff + 32'd1;
                           perd_ff[in_idx] <= in_per != '0;
                           cbm_ff[in_idx] <= in_cb;
                           pend_ff[in_idx] <= 1'b1;
                           if (!pend_ff[in_idx]) cnt_ff <= cnt_ff + CW'(1);
                        end
                        ovalid_ff <= 1'b1;
                     end
                     tqe_pkg::REQ_CANCEL: begin
                        ev_ff <= '{kind: tqe_pkg::EV_CANCEL, tmr: in_id, cb: 1'b0,
                                   wa: in_ok && pend_ff[in_idx], last: 1'b1};
                        if (in_ok && pend_ff[in_idx]) begin
                           pend_ff[in_idx] <= 1'b0;
                           cnt_ff <= cnt_ff - CW'(1);
                        end
                        ovalid_ff <= 1'b1;
                     end
                     tqe_pkg::REQ_SET: begin
                        ev_ff <= '{kind: tqe_pkg::EV_SET, tmr: 5'd0, cb: 1'b0,
                                   wa: 1'b0, last: 1'b1};
                        now_ff <= in_due;
                        ovalid_ff <= 1'b1;
                     end
                     default: begin
                        now_ff <= now_ff + {44'd0, inc_ff};
                        done_ff <= '0;
                        idx_ff <= '0; best_ok_ff <= 1'b0; rd_ok_ff <= 1'b0;
                        scan_end_ff <= 1'b0;
                        state_ff <= ST_SCAN;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               // rd_* holds slot rd_idx_ff when rd_ok_ff
               if (rd_ok_ff && pend_ff[rd_idx_ff] && !done_ff[rd_idx_ff] && is_due
                   && better) begin
                  best_ok_ff <= 1'b1; best_ff <= rd_idx_ff;
                  best_due_ff <= rd_due_ff; best_ord_ff <= rd_ord_ff;
               end
               rd_idx_ff <= idx_ff;
               rd_ok_ff <= !scan_end_ff;
               if (scan_end_ff && !rd_ok_ff) begin
                  state_ff <= ST_SCANRD;
               end else if (32'(idx_ff) == TIMER_SLOTS - 1 || scan_end_ff) begin
                  scan_end_ff <= 1'b1;
               end else begin
                  idx_ff <= idx_ff + IW'(1);
               end
            end
            ST_SCANRD: begin
               state_ff <= ST_FIRE;
            end
            ST_FIRE: begin
               if (!ovalid_ff) begin
                  if (best_ok_ff) begin
                     ev_ff <= '{kind: tqe_pkg::EV_EXPIRED, tmr: 5'(best_ff),
                                cb: cbm_ff[best_ff], wa: 1'b0, last: 1'b0};
                     done_ff[best_ff] <= 1'b1;
                     if (perd_ff[best_ff]) begin
                        due_mem[best_ff] <= best_due_ff + {1'b0, rd_per_ff};
                        ord_mem[best_ff] <= seq_ff;
                        seq_ff <= seq_ff + 32'd1;
                     end else begin
                        pend_ff[best_ff] <= 1'b0;
                        cnt_ff <= cnt_ff - CW'(1);
                     end
                     idx_ff <= '0; best_ok_ff <= 1'b0; rd_ok_ff <= 1'b0;
                     scan_end_ff <= 1'b0;
                     state_ff <= ST_OUT;
                  end else begin
                     ev_ff <= '{kind: tqe_pkg::EV_TICK, tmr: 5'd0, cb: 1'b0,
                                wa: 1'b0, last: 1'b1};
                     state_ff <= ST_IDLE;
                  end
                  ovalid_ff <= 1'b1;
               end
            end
            ST_OUT: begin
               state_ff <= ST_SCAN;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_CLK(a_cnt_max, clock, reset, 32'(cnt_ff) <= TIMER_SLOTS)
   `ASSERT_CLK(a_busy, clock, reset, (state_ff != ST_IDLE) |-> !req_tready)
   `ASSERT_CLK(a_cnt_pop, clock, reset, (32'(cnt_ff) == $countones(pend_ff)))
endmodule

/* design/tqe_cmp.sv */
//------------------------------------------------------------------------------
// tqe_cmp
// Shared compare unit: one candidate against the best and against now.
//------------------------------------------------------------------------------
module tqe_cmp (
   input  logic [63:0] cand_due,
   input  logic [31:0] cand_ord,
   input  logic [63:0] best_due,
   input  logic [31:0] best_ord,
   input  logic        best_ok,
   input  logic [63:0] now,
   output logic        is_due,
   output logic        better
);
   logic [63:0] cx, bx, nx;
   assign cx = cand_due ^ tqe_pkg::SIGN64;
   assign bx = best_due ^ tqe_pkg::SIGN64;
   assign nx = now ^ tqe_pkg::SIGN64;
   assign is_due = cx <= nx;
   assign better = !best_ok || (cx < bx) || ((cx == bx) && (cand_ord < best_ord));
endmodule
